@@ hdl/slt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, token kind codes, character classes and keyword table for the lexer.
package slt_pkg;

    localparam int MAX_SOURCE_LEN_DEF = 65536;
    localparam int MAX_TOKEN_LEN_DEF  = 255;
    localparam int KW_MAX             = 6;
    localparam int KW_COUNT           = 8;
    localparam int RUN_MAX            = 3;

    // Token kinds; keywords take the codes 0..7 in keyword table order.
    localparam logic [4:0] KIND_INT    = 5'd8;
    localparam logic [4:0] KIND_FLOAT  = 5'd9;
    localparam logic [4:0] KIND_IDENT  = 5'd10;
    localparam logic [4:0] KIND_SEMI   = 5'd11;
    localparam logic [4:0] KIND_PLUS   = 5'd12;
    localparam logic [4:0] KIND_MINUS  = 5'd13;
    localparam logic [4:0] KIND_STAR   = 5'd14;
    localparam logic [4:0] KIND_DIVIDE = 5'd15;
    localparam logic [4:0] KIND_CARET  = 5'd16;
    localparam logic [4:0] KIND_ASSIGN = 5'd17;
    localparam logic [4:0] KIND_LPAREN = 5'd18;
    localparam logic [4:0] KIND_RPAREN = 5'd19;
    localparam logic [4:0] KIND_LBRACE = 5'd20;
    localparam logic [4:0] KIND_RBRACE = 5'd21;
    localparam logic [4:0] KIND_COMMA  = 5'd22;
    localparam logic [4:0] KIND_LAST   = KIND_COMMA;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef logic [KW_MAX-1:0][7:0] kw_chars_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [7:0]  length;
        logic        sat;
    } token_t;

    typedef token_t [RUN_MAX-1:0] token_list_t;

    // Tokens produced by one source byte, in emission order.
    typedef struct packed {
        logic [1:0]  cnt;
        token_list_t tok;
    } run_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] kind;
    } kw_hit_t;

    function automatic logic is_numeral(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == "_");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
               (c == 8'h0B) || (c == 8'h0C);
    endfunction

    // Single-byte punctuation; anything unknown becomes a one-byte identifier.
    function automatic logic [4:0] punct_kind(logic [7:0] c);
        logic [4:0] k;
        case (c)
            ";":     k = KIND_SEMI;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_DIVIDE;
            "^":     k = KIND_CARET;
            "=":     k = KIND_ASSIGN;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ",":     k = KIND_COMMA;
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] kw_len(logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0:    n = 3'd4;
            3'd1:    n = 3'd4;
            3'd2:    n = 3'd2;
            3'd3:    n = 3'd3;
            3'd4:    n = 3'd5;
            3'd5:    n = 3'd6;
            3'd6:    n = 3'd4;
            3'd7:    n = 3'd5;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Byte 0 of the result is the first letter of the keyword.
    function automatic kw_chars_t kw_text(logic [2:0] k);
        kw_chars_t r;
        r = '0;
        case (k)
            3'd0:    begin r[0] = "e"; r[1] = "l"; r[2] = "s"; r[3] = "e"; end
            3'd1:    begin r[0] = "e"; r[1] = "x"; r[2] = "i"; r[3] = "t"; end
            3'd2:    begin r[0] = "i"; r[1] = "f"; end
            3'd3:    begin r[0] = "i"; r[1] = "n"; r[2] = "t"; end
            3'd4:
            begin
                r[0] = "f"; r[1] = "l"; r[2] = "o"; r[3] = "a"; r[4] = "t";
            end
            3'd5:
            begin
                r[0] = "r"; r[1] = "e"; r[2] = "t"; r[3] = "u"; r[4] = "r"; r[5] = "n";
            end
            3'd6:    begin r[0] = "v"; r[1] = "o"; r[2] = "i"; r[3] = "d"; end
            3'd7:
            begin
                r[0] = "w"; r[1] = "h"; r[2] = "i"; r[3] = "l"; r[4] = "e";
            end
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/slt_kw_match.sv @@
`timescale 1ns / 1ps
// Keyword matcher: compares the stored identifier prefix against the keyword table.
module slt_kw_match (
    input  slt_pkg::kw_chars_t chars,
    input  logic [2:0]         len,
    input  logic               eligible,
    output slt_pkg::kw_hit_t   result
);

    always_comb
    begin
        slt_pkg::kw_chars_t text;
        logic               eq;
        result = '0;
        for (int k = 0; k < slt_pkg::KW_COUNT; k++)
        begin
            text = slt_pkg::kw_text(3'(k));
            eq   = eligible && (len == slt_pkg::kw_len(3'(k)));
            for (int j = 0; j < slt_pkg::KW_MAX; j++)
            begin
                if ((3'(j) < len) && (chars[j] != text[j]))
                begin
                    eq = 1'b0;
                end
            end
            if (eq && !result.hit)
            begin
                result.hit  = 1'b1;
                result.kind = 5'(k);
            end
        end
    end

endmodule

@@ hdl/slt_scan.sv @@
`timescale 1ns / 1ps
// Scan state machine: per-byte next state and the run of tokens the byte produces.
module slt_scan #(
    parameter int MAX_SOURCE_LEN = slt_pkg::MAX_SOURCE_LEN_DEF,
    parameter int MAX_TOKEN_LEN  = slt_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [7:0]    ch,
    input  logic          eos,
    output slt_pkg::run_t run
);

    localparam int POS_W = $clog2(MAX_SOURCE_LEN);
    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    typedef enum logic [3:0] {
        M_IDLE, M_INT, M_INT_DOT, M_FLOAT, M_IDENT, M_SLASH, M_LINE, M_BLOCK, M_BLOCK_STAR
    } mode_t;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic               ovf;
        slt_pkg::kw_chars_t kw;
    } word_t;

    typedef struct packed {
        logic [1:0]      cnt;
        slt_pkg::token_t a;
        slt_pkg::token_t b;
    } flush_t;

    mode_t              mode_reg, mode_next, mode_a;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   start_reg, start_next, start_a;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ovf_reg, ovf_next;
    slt_pkg::kw_chars_t kw_reg, kw_next;
    word_t              word_reg, word_a;
    logic [POS_W-1:0]   prev_pos, pos_inc;
    slt_pkg::run_t      run_a;
    slt_pkg::kw_hit_t   kw_old, kw_new;

    function automatic word_t grow_f(word_t w, logic [7:0] c);
        word_t r;
        r = w;
        if (w.len < LEN_W'(slt_pkg::KW_MAX))
        begin
            r.kw[w.len[2:0]] = c;
        end
        if (w.len < LEN_W'(MAX_TOKEN_LEN))
        begin
            r.len = w.len + 1'b1;
        end
        else
        begin
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    function automatic slt_pkg::token_t make_tok(logic [4:0] kind, logic [POS_W-1:0] start,
                                                 logic [LEN_W-1:0] len, logic ovf);
        logic [POS_W+15:0] sx;
        logic [LEN_W+7:0]  lx;
        slt_pkg::token_t   t;
        sx     = {16'b0, start};
        lx     = {8'b0, len};
        t.kind  = kind;
        t.start = sx[15:0];
        if (lx > (LEN_W + 8)'(255))
        begin
            t.length = 8'd255;
            t.sat    = 1'b1;
        end
        else
        begin
            t.length = lx[7:0];
            t.sat    = ovf;
        end
        return t;
    endfunction

    function automatic flush_t flush_f(mode_t m, logic [POS_W-1:0] st, word_t w,
                                       slt_pkg::kw_hit_t kh, logic [POS_W-1:0] pp);
        flush_t f;
        f = '0;
        case (m)
            M_INT:
            begin
                f.cnt = 2'd1;
                f.a   = make_tok(slt_pkg::KIND_INT, st, w.len, w.ovf);
            end
            M_INT_DOT:
            begin
                f.cnt = 2'd2;
                f.a   = make_tok(slt_pkg::KIND_INT, st, w.len, w.ovf);
                f.b   = make_tok(slt_pkg::KIND_IDENT, pp, LEN_W'(1), 1'b0);
            end
            M_FLOAT:
            begin
                f.cnt = 2'd1;
                f.a   = make_tok(slt_pkg::KIND_FLOAT, st, w.len, w.ovf);
            end
            M_IDENT:
            begin
                f.cnt = 2'd1;
                f.a   = kh.hit ? make_tok(kh.kind, st, w.len, 1'b0)
                               : make_tok(slt_pkg::KIND_IDENT, st, w.len, w.ovf);
            end
            M_SLASH:
            begin
                f.cnt = 2'd1;
                f.a   = make_tok(slt_pkg::KIND_DIVIDE, pp, LEN_W'(1), 1'b0);
            end
            default: f = '0;
        endcase
        return f;
    endfunction

    assign word_reg = '{len: len_reg, ovf: ovf_reg, kw: kw_reg};
    assign prev_pos = (pos_reg == '0) ? POS_W'(MAX_SOURCE_LEN - 1) : pos_reg - 1'b1;
    assign pos_inc  = (pos_reg == POS_W'(MAX_SOURCE_LEN - 1)) ? '0 : pos_reg + 1'b1;

    slt_kw_match u_kw_old (
        .chars    (word_reg.kw),
        .len      (word_reg.len[2:0]),
        .eligible (!word_reg.ovf && (word_reg.len <= LEN_W'(slt_pkg::KW_MAX))),
        .result   (kw_old)
    );

    slt_kw_match u_kw_new (
        .chars    (word_a.kw),
        .len      (word_a.len[2:0]),
        .eligible (!word_a.ovf && (word_a.len <= LEN_W'(slt_pkg::KW_MAX))),
        .result   (kw_new)
    );

    // Scan the byte: extend the pending token, or close it and rescan from idle.
    always_comb
    begin : scan_step
        flush_t               fl;
        logic                 do_flush;
        logic                 do_idle;
        logic [1:0]           n;
        slt_pkg::token_list_t t;
        fl       = flush_f(mode_reg, start_reg, word_reg, kw_old, prev_pos);
        do_flush = 1'b0;
        do_idle  = 1'b0;
        n        = 2'd0;
        t        = '0;
        mode_a   = mode_reg;
        start_a  = start_reg;
        word_a   = word_reg;
        case (mode_reg)
            M_INT:
            begin
                if (slt_pkg::is_numeral(ch))    word_a = grow_f(word_reg, ch);
                else if (ch == slt_pkg::CH_DOT) mode_a = M_INT_DOT;
                else                            do_flush = 1'b1;
            end
            M_INT_DOT:
            begin
                if (slt_pkg::is_numeral(ch))
                begin
                    word_a = grow_f(grow_f(word_reg, slt_pkg::CH_DOT), ch);
                    mode_a = M_FLOAT;
                end
                else
                begin
                    do_flush = 1'b1;
                end
            end
            M_FLOAT:
            begin
                if (slt_pkg::is_numeral(ch)) word_a = grow_f(word_reg, ch);
                else                         do_flush = 1'b1;
            end
            M_IDENT:
            begin
                if (slt_pkg::is_numeral(ch) || slt_pkg::is_letter(ch))
                    word_a = grow_f(word_reg, ch);
                else
                    do_flush = 1'b1;
            end
            M_SLASH:
            begin
                if (ch == slt_pkg::CH_SLASH)     mode_a = M_LINE;
                else if (ch == slt_pkg::CH_STAR) mode_a = M_BLOCK;
                else                             do_flush = 1'b1;
            end
            M_LINE:
            begin
                if (ch == slt_pkg::CH_NEWLINE) mode_a = M_IDLE;
            end
            M_BLOCK:
            begin
                if (ch == slt_pkg::CH_STAR) mode_a = M_BLOCK_STAR;
            end
            M_BLOCK_STAR:
            begin
                if (ch == slt_pkg::CH_SLASH)     mode_a = M_IDLE;
                else if (ch != slt_pkg::CH_STAR) mode_a = M_BLOCK;
            end
            default: do_idle = 1'b1;
        endcase
        if (do_flush)
        begin
            t[0]    = fl.a;
            t[1]    = fl.b;
            n       = fl.cnt;
            mode_a  = M_IDLE;
            do_idle = 1'b1;
        end
        if (do_idle)
        begin
            if (slt_pkg::is_numeral(ch) || slt_pkg::is_letter(ch))
            begin
                mode_a     = slt_pkg::is_numeral(ch) ? M_INT : M_IDENT;
                start_a    = pos_reg;
                word_a.len = '0;
                word_a.ovf = 1'b0;
                word_a     = grow_f(word_a, ch);
            end
            else if (slt_pkg::is_space(ch))
            begin
                mode_a = M_IDLE;
            end
            else if (ch == slt_pkg::CH_SLASH)
            begin
                mode_a = M_SLASH;
            end
            else
            begin
                mode_a = M_IDLE;
                t[n]   = make_tok(slt_pkg::punct_kind(ch), pos_reg, LEN_W'(1), 1'b0);
                n      = n + 2'd1;
            end
        end
        run_a.cnt = n;
        run_a.tok = t;
    end

    // End of source: flush what the byte left pending and return to the reset state.
    always_comb
    begin : eos_step
        flush_t        fl;
        slt_pkg::run_t r;
        fl         = flush_f(mode_a, start_a, word_a, kw_new, pos_reg);
        r          = run_a;
        mode_next  = mode_a;
        pos_next   = pos_inc;
        start_next = start_a;
        len_next   = word_a.len;
        ovf_next   = word_a.ovf;
        kw_next    = word_a.kw;
        if (eos)
        begin
            if (fl.cnt != 2'd0)
            begin
                r.tok[r.cnt] = fl.a;
                r.cnt        = r.cnt + 2'd1;
            end
            if (fl.cnt == 2'd2)
            begin
                r.tok[r.cnt] = fl.b;
                r.cnt        = r.cnt + 2'd1;
            end
            mode_next  = M_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            ovf_next   = 1'b0;
        end
        run = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (en)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Identifier prefix bytes are only read after being written.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kw_reg <= kw_next;
        end
    end

endmodule

@@ hdl/slt_out_buf.sv @@
`timescale 1ns / 1ps
// Result register: holds one byte's run of tokens and drains it one transfer at a time.
module slt_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  slt_pkg::run_t   run,
    input  logic            stall,
    output logic            valid,
    output slt_pkg::token_t token,
    output logic            last,
    output logic            free
);

    slt_pkg::token_list_t slot_reg;
    logic [1:0]           cnt_reg, cnt_next;
    logic [1:0]           head_reg, head_next;
    logic                 take;

    assign valid = (cnt_reg != 2'd0);
    assign token = slot_reg[head_reg];
    assign last  = (cnt_reg == 2'd1);
    assign take  = valid && !stall;
    assign free  = (cnt_reg == 2'd0) || (last && !stall);

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (load)
        begin
            cnt_next  = run.cnt;
            head_next = 2'd0;
        end
        else if (take)
        begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = head_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            head_reg <= 2'd0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= run.tok;
        end
    end

endmodule

@@ hdl/source_lexer_tokenizer.sv @@
`timescale 1ns / 1ps
// Top level of the streaming source lexer: input register, scanner and result register.
//
// Source bytes enter on the byte channel (ch, end_of_source, byte_valid, byte_stall) and
// tokens leave on the token channel (token_kind, start_offset, token_length,
// length_saturated, last_of_run, token_valid, token_stall). A transfer happens at a rising
// edge where valid is high and stall is low.
// Each accepted byte waits in the input register until the result register is free; the
// scanner then decides, in the same cycle, every token the byte produces and loads them
// into the result register, from which the first token of the byte is offered.
// Throughput is one byte per cycle while each byte yields at most one token and the
// receiver does not stall. A byte that yields k tokens (k up to 3) holds the result
// register for k token transfers, and the byte channel stalls while they drain.
// last_of_run marks the final token of one byte. A byte with end_of_source set flushes
// any pending token and puts the scanner back at offset 0.
// When the receiver stalls, the current token holds; one further byte is still taken
// into the input register, then byte_stall rises.
// Reset (rst_n low, asynchronous) drops buffered bytes and tokens and returns the
// scanner to idle at offset 0.
module source_lexer_tokenizer #(
    parameter int MAX_SOURCE_LEN = slt_pkg::MAX_SOURCE_LEN_DEF,
    parameter int MAX_TOKEN_LEN  = slt_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  ch,
    input  logic        end_of_source,
    input  logic        byte_valid,
    output logic        byte_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] start_offset,
    output logic [7:0]  token_length,
    output logic        length_saturated,
    output logic        last_of_run,
    output logic        token_valid,
    input  logic        token_stall
);

    logic            in_valid_reg, in_valid_next;
    logic [7:0]      ch_reg;
    logic            eos_reg;
    logic            accept;
    logic            fire;
    logic            buf_free;
    slt_pkg::run_t   run;
    slt_pkg::token_t token;

    // Advance the held byte into the scanner once the result register can take its run.
    assign fire       = in_valid_reg && buf_free;
    assign byte_stall = in_valid_reg && !buf_free;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Byte payload needs no reset; it is qualified by in_valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= ch;
            eos_reg <= end_of_source;
        end
    end

    slt_scan #(
        .MAX_SOURCE_LEN (MAX_SOURCE_LEN),
        .MAX_TOKEN_LEN  (MAX_TOKEN_LEN)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (fire),
        .ch    (ch_reg),
        .eos   (eos_reg),
        .run   (run)
    );

    slt_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire),
        .run   (run),
        .stall (token_stall),
        .valid (token_valid),
        .token (token),
        .last  (last_of_run),
        .free  (buf_free)
    );

    assign token_kind       = token.kind;
    assign start_offset     = token.start;
    assign token_length     = token.length;
    assign length_saturated = token.sat;

`ifndef SYNTHESIS
    // A token that is not the last of its run is followed by another one.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_stall && !last_of_run |=> token_valid)
        else $error("token run ended before its last token");

    // The byte side only stalls while tokens are waiting to be taken.
    a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> token_valid)
        else $error("byte channel stalled with empty result register");

    // Every offered token has a legal kind and a nonzero length.
    a_token_sane: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> (token_kind <= slt_pkg::KIND_LAST) && (token_length != 8'd0))
        else $error("malformed token offered");

    // A run is loaded only when the previous one has fully drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fire && token_valid |-> last_of_run && !token_stall)
        else $error("result register overwritten before drained");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the streaming source lexer, with a token scoreboard class.
module tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int ITEM_COUNT   = 170;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 2000;

    // Scanner modes kept by the predictor between bytes.
    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_INT, SCAN_INT_DOT, SCAN_FLOAT, SCAN_WORD,
        SCAN_SLASH, SCAN_LINE, SCAN_BLOCK, SCAN_BLOCK_STAR
    } scan_mode_t;

    // Shapes of random source fragments.
    typedef enum int {
        FRAG_KEYWORD, FRAG_WORD, FRAG_INT, FRAG_FLOAT, FRAG_INT_DOT,
        FRAG_PUNCT, FRAG_BLANK, FRAG_LINE_NOTE, FRAG_BLOCK_NOTE, FRAG_NOISE
    } frag_shape_t;

    // Receiver stall styles, each held for a random stretch of cycles.
    typedef enum int { STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY } stall_style_t;

    typedef struct {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [7:0]  length;
        logic        sat;
        logic        last;
    } lexeme_t;

    class lexer_scoreboard;
        static string keywords[slt_pkg::KW_COUNT] = '{"else", "exit", "if", "int", "float",
                                                      "return", "void", "while"};
        static string punctuation = ";+-*/^=(){},";

        lexeme_t     pending[$];
        lexeme_t     this_byte[$];
        int          failures;
        scan_mode_t  mode;
        logic [15:0] pos;
        logic [15:0] start;
        int unsigned len;
        logic        ovf;
        logic [7:0]  word[slt_pkg::KW_MAX];

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            mode  = SCAN_IDLE;
            pos   = '0;
            start = '0;
            len   = 0;
            ovf   = 1'b0;
            foreach (word[i]) word[i] = '0;
        endfunction

        static function bit is_numeral_byte(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        static function bit is_letter_byte(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
        endfunction

        static function bit is_blank_byte(logic [7:0] c);
            return c == " " || c == "\t" || c == "\n" || c == "\r" || c == 8'd11 || c == 8'd12;
        endfunction

        function void put_token(logic [4:0] kind, logic [15:0] at, int unsigned n, logic sat);
            lexeme_t t;
            if (this_byte.size() >= slt_pkg::RUN_MAX) return;
            t.kind   = kind;
            t.start  = at;
            t.length = 8'(n > 255 ? 255 : n);
            t.sat    = sat || n > 255;
            t.last   = 1'b0;
            this_byte.push_back(t);
        endfunction

        function void grow(logic [7:0] c);
            if (len < slt_pkg::KW_MAX) word[len] = c;
            if (len < slt_pkg::MAX_TOKEN_LEN_DEF) len++;
            else ovf = 1'b1;
        endfunction

        function void open_token(scan_mode_t m, logic [7:0] c);
            mode  = m;
            start = pos;
            len   = 0;
            ovf   = 1'b0;
            grow(c);
        endfunction

        // Match short words against the keyword table, else report an identifier.
        function void close_word();
            bit same;
            if (!ovf && len <= slt_pkg::KW_MAX)
            begin
                for (int k = 0; k < slt_pkg::KW_COUNT; k++)
                begin
                    if (keywords[k].len() == len)
                    begin
                        same = 1'b1;
                        for (int i = 0; i < len; i++)
                            if (keywords[k][i] != word[i]) same = 1'b0;
                        if (same)
                        begin
                            put_token(5'(k), start, len, 1'b0);
                            return;
                        end
                    end
                end
            end
            put_token(slt_pkg::KIND_IDENT, start, len, ovf);
        endfunction

        function void flush();
            case (mode)
                SCAN_INT:   put_token(slt_pkg::KIND_INT, start, len, ovf);
                SCAN_INT_DOT:
                begin
                    put_token(slt_pkg::KIND_INT, start, len, ovf);
                    put_token(slt_pkg::KIND_IDENT, 16'(pos - 1), 1, 1'b0);
                end
                SCAN_FLOAT: put_token(slt_pkg::KIND_FLOAT, start, len, ovf);
                SCAN_WORD:  close_word();
                SCAN_SLASH: put_token(slt_pkg::KIND_DIVIDE, 16'(pos - 1), 1, 1'b0);
                default:    ;
            endcase
            mode = SCAN_IDLE;
        endfunction

        function void start_fresh(logic [7:0] c);
            logic [4:0] kind;
            if (is_numeral_byte(c)) open_token(SCAN_INT, c);
            else if (is_letter_byte(c)) open_token(SCAN_WORD, c);
            else if (is_blank_byte(c)) ;
            else if (c == slt_pkg::CH_SLASH) mode = SCAN_SLASH;
            else
            begin
                kind = slt_pkg::KIND_IDENT;
                for (int k = 0; k < punctuation.len(); k++)
                    if (punctuation[k] == c) kind = slt_pkg::KIND_SEMI + 5'(k);
                put_token(kind, pos, 1, 1'b0);
            end
        endfunction

        function void scan_byte(logic [7:0] c);
            case (mode)
                SCAN_INT:
                begin
                    if (is_numeral_byte(c))
                    begin
                        grow(c);
                        return;
                    end
                    if (c == slt_pkg::CH_DOT)
                    begin
                        mode = SCAN_INT_DOT;
                        return;
                    end
                end
                SCAN_INT_DOT:
                begin
                    if (is_numeral_byte(c))
                    begin
                        grow(slt_pkg::CH_DOT);
                        grow(c);
                        mode = SCAN_FLOAT;
                        return;
                    end
                end
                SCAN_FLOAT:
                begin
                    if (is_numeral_byte(c))
                    begin
                        grow(c);
                        return;
                    end
                end
                SCAN_WORD:
                begin
                    if (is_numeral_byte(c) || is_letter_byte(c))
                    begin
                        grow(c);
                        return;
                    end
                end
                SCAN_SLASH:
                begin
                    if (c == slt_pkg::CH_SLASH)
                    begin
                        mode = SCAN_LINE;
                        return;
                    end
                    if (c == slt_pkg::CH_STAR)
                    begin
                        mode = SCAN_BLOCK;
                        return;
                    end
                end
                SCAN_LINE:
                begin
                    if (c == slt_pkg::CH_NEWLINE) mode = SCAN_IDLE;
                    return;
                end
                SCAN_BLOCK:
                begin
                    if (c == slt_pkg::CH_STAR) mode = SCAN_BLOCK_STAR;
                    return;
                end
                SCAN_BLOCK_STAR:
                begin
                    if (c == slt_pkg::CH_SLASH) mode = SCAN_IDLE;
                    else if (c != slt_pkg::CH_STAR) mode = SCAN_BLOCK;
                    return;
                end
                default: mode = SCAN_IDLE;
            endcase
            flush();
            start_fresh(c);
        endfunction

        // Predict the tokens of one accepted byte and queue them in order.
        function void take_byte(logic [7:0] c, logic eos);
            this_byte.delete();
            scan_byte(c);
            pos = 16'(pos + 1);
            if (eos)
            begin
                flush();
                restart();
            end
            foreach (this_byte[i])
            begin
                this_byte[i].last = (i == this_byte.size() - 1);
                pending.push_back(this_byte[i]);
            end
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                failures++;
            end
        endfunction

        function void match_token(logic [4:0] kind, logic [15:0] at, logic [7:0] n,
                                  logic sat, logic last);
            lexeme_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: token kind %0d start %0d length %0d expected none",
                         $time, kind, at, n);
                failures++;
                return;
            end
            want = pending.pop_front();
            compare_field("token_kind", want.kind, kind);
            compare_field("start_offset", want.start, at);
            compare_field("token_length", want.length, n);
            compare_field("length_saturated", want.sat, sat);
            compare_field("last_of_run", want.last, last);
        endfunction
    endclass

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic [7:0]  ch               = '0;
    logic        end_of_source    = 1'b0;
    logic        byte_valid       = 1'b0;
    logic        byte_stall;
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [7:0]  token_length;
    logic        length_saturated;
    logic        last_of_run;
    logic        token_valid;
    logic        token_stall      = 1'b0;

    lexer_scoreboard board;

    int           burst_left   = 0;
    bit           draining     = 1'b0;
    int           sent_items   = 0;
    int           quiet_cycles = 0;
    stall_style_t stall_style  = STALL_NONE;
    int           stall_left   = 0;
    logic         stall_now;

    source_lexer_tokenizer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .ch               (ch),
        .end_of_source    (end_of_source),
        .byte_valid       (byte_valid),
        .byte_stall       (byte_stall),
        .token_kind       (token_kind),
        .start_offset     (start_offset),
        .token_length     (token_length),
        .length_saturated (length_saturated),
        .last_of_run      (last_of_run),
        .token_valid      (token_valid),
        .token_stall      (token_stall)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver side: pick a stall style, hold it for a random stretch, then switch.
    // Drop all stalls once the final drain starts so stray tokens surface quickly.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= stall_style_t'($urandom_range(0, STALL_HEAVY));
            stall_left  <= $urandom_range(24, 160);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            STALL_NONE:     stall_now = 1'b0;
            STALL_LIGHT:    stall_now = ($urandom_range(0, 4) == 0);
            STALL_PERIODIC: stall_now = (stall_left % 4 == 0);
            default:        stall_now = ($urandom_range(0, 3) != 0);
        endcase
        token_stall <= draining ? 1'b0 : stall_now;
    end

    // Monitor both channels at the clock edge. A byte transfer always precedes its
    // tokens, so note the byte before checking any token.
    // Count cycles without any transfer for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                board.take_byte(ch, end_of_source);
            if (token_valid && !token_stall)
                board.match_token(token_kind, start_offset, token_length,
                                  length_saturated, last_of_run);
            if ((byte_valid && !byte_stall) || (token_valid && !token_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run when the block stops moving.
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("tb failed");
        $finish;
    end

    function automatic logic [7:0] pick_letter();
        string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        return letters[$urandom_range(0, letters.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_word_char();
        return ($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter();
    endfunction

    function automatic logic [7:0] pick_blank();
        string blanks = " \t\n\r\013\014";
        return blanks[$urandom_range(0, blanks.len() - 1)];
    endfunction

    // Offer one byte and hold it until the transfer. Start a new burst, after a
    // random gap, whenever the current one runs out.
    task automatic send_byte(logic [7:0] c, bit last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        sent_items++;
        ch            <= c;
        end_of_source <= last;
        byte_valid    <= 1'b1;
        do @(posedge clk); while (byte_stall);
    endtask

    // Send a string; mark its final byte as end of source when asked.
    task automatic send_text(string s, bit eos);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eos && i == s.len() - 1);
    endtask

    // Build and send one random fragment. The first fragments walk through every
    // keyword and every punctuation byte; later ones pick a shape at random.
    // Comments may be cut short by end of source.
    task automatic send_fragment(int index);
        logic [7:0]  frag[$];
        frag_shape_t shape;
        string       kw;
        string       after_dot = "a_ ;./*x\n";
        string       note_chars = "*/a \n";
        int          n;
        bit          cut;
        bit          eos;
        if (index < 2 * slt_pkg::KW_COUNT + 8)
            shape = (index % 2) ? FRAG_PUNCT : FRAG_KEYWORD;
        else
            shape = frag_shape_t'($urandom_range(0, FRAG_NOISE));
        cut = 1'b0;
        case (shape)
            FRAG_KEYWORD:
            begin
                kw = lexer_scoreboard::keywords[(index < 2 * slt_pkg::KW_COUNT + 8) ?
                                                (index / 2) % slt_pkg::KW_COUNT :
                                                $urandom_range(0, slt_pkg::KW_COUNT - 1)];
                for (int i = 0; i < kw.len(); i++) frag.push_back(kw[i]);
            end
            FRAG_WORD:
            begin
                kw = lexer_scoreboard::keywords[$urandom_range(0, slt_pkg::KW_COUNT - 1)];
                case ($urandom_range(0, 2))
                    0:       for (int i = 0; i < kw.len() - 1; i++) frag.push_back(kw[i]);
                    1:
                    begin
                        for (int i = 0; i < kw.len(); i++) frag.push_back(kw[i]);
                        frag.push_back(pick_word_char());
                    end
                    default:
                    begin
                        frag.push_back(pick_letter());
                        n = $urandom_range(0, 6);
                        repeat (n) frag.push_back(pick_word_char());
                    end
                endcase
            end
            FRAG_INT:
            begin
                n = $urandom_range(1, 4);
                repeat (n) frag.push_back(pick_digit());
            end
            FRAG_FLOAT:
            begin
                n = $urandom_range(1, 3);
                repeat (n) frag.push_back(pick_digit());
                frag.push_back(slt_pkg::CH_DOT);
                n = $urandom_range(1, 3);
                repeat (n) frag.push_back(pick_digit());
            end
            FRAG_INT_DOT:
            begin
                n = $urandom_range(1, 3);
                repeat (n) frag.push_back(pick_digit());
                frag.push_back(slt_pkg::CH_DOT);
                frag.push_back(after_dot[$urandom_range(0, after_dot.len() - 1)]);
            end
            FRAG_PUNCT:
            begin
                n = (index < 2 * slt_pkg::KW_COUNT + 8) ? (index / 2) % 12
                                                        : $urandom_range(0, 11);
                frag.push_back(lexer_scoreboard::punctuation[n]);
            end
            FRAG_BLANK:
            begin
                n = $urandom_range(1, 3);
                repeat (n) frag.push_back(pick_blank());
            end
            FRAG_LINE_NOTE:
            begin
                cut = ($urandom_range(0, 5) == 0);
                frag.push_back(slt_pkg::CH_SLASH);
                frag.push_back(slt_pkg::CH_SLASH);
                n = $urandom_range(0, 6);
                repeat (n) frag.push_back(8'($urandom_range(32, 126)));
                if (!cut) frag.push_back(slt_pkg::CH_NEWLINE);
            end
            FRAG_BLOCK_NOTE:
            begin
                cut = ($urandom_range(0, 5) == 0);
                frag.push_back(slt_pkg::CH_SLASH);
                frag.push_back(slt_pkg::CH_STAR);
                n = $urandom_range(0, 6);
                repeat (n) frag.push_back(note_chars[$urandom_range(0, note_chars.len() - 1)]);
                if (!cut)
                begin
                    frag.push_back(slt_pkg::CH_STAR);
                    frag.push_back(slt_pkg::CH_SLASH);
                end
            end
            default: frag.push_back(8'($urandom_range(0, 255)));
        endcase
        if (!cut && $urandom_range(0, 1)) frag.push_back(pick_blank());
        eos = cut || ($urandom_range(0, 11) == 0);
        foreach (frag[i]) send_byte(frag[i], eos && i == frag.size() - 1);
    endtask

    initial
    begin
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: dot with no digit after it, a float, a lone slash,
        // a block comment whose opening star must not close it, a line comment,
        // the lowest and highest byte, end of source right after a dot, and a
        // block comment left open at end of source.
        send_text("1.x ", 1'b0);
        send_text("2.5;", 1'b0);
        send_text("a/b ", 1'b0);
        send_text("/*/x**/", 1'b0);
        send_text("//c\n", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("9.", 1'b1);
        send_text("/*", 1'b1);

        // Random part: mostly well-formed fragments with random content.
        for (int i = 0; sent_items < ITEM_COUNT; i++)
            send_fragment(i);

        byte_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        draining <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending.size() != 0)
        begin
            $display("%0t: %0d tokens expected but never seen", $time, board.pending.size());
            board.failures++;
        end
        if (board.failures == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ source_lexer_tokenizer.f @@
hdl/slt_pkg.sv
hdl/slt_kw_match.sv
hdl/slt_scan.sv
hdl/slt_out_buf.sv
hdl/source_lexer_tokenizer.sv
tb/sv/tb.sv
